>>> hdl/prr_pkg.sv
`default_nettype none

package prr_pkg;

  // Default storage sizes
  localparam int RING_DEPTH_DEF = 512;
  localparam int COEF_DEPTH_DEF = 512;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int CIDX_W   = 9;
  localparam int RATIO_W  = 5;
  localparam int TAPS_W   = 10;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  // Register reset values
  localparam logic [RATIO_W-1:0] UP_RATIO_RST  = 5'd8;
  localparam logic [RATIO_W-1:0] DOWN_RATIO_RST = 5'd5;
  localparam logic [TAPS_W-1:0]  TAP_COUNT_RST = 10'd512;
  localparam logic [TAPS_W-1:0]  DISCARD_RST   = 10'd0;
  localparam logic [RATIO_W-1:0] RATIO_MAX     = 5'd16;

  // Register indexes on the configuration port
  localparam int          REG_IDX_W           = 2;
  localparam logic [1:0] REG_UP_RATIO        = 2'd0;
  localparam logic [1:0] REG_DOWN_RATIO      = 2'd1;
  localparam logic [1:0] REG_TAP_COUNT       = 2'd2;
  localparam logic [1:0] REG_STARTUP_DISCARD = 2'd3;

  // Item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Queue between intake and datapath
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic                     is_coef;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CIDX_W-1:0]        coef_addr;
    logic                     coef_ok;
    logic signed [COEF_W-1:0] coef_value;
  } prr_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0] up;
    logic [RATIO_W-1:0] down;
    logic [TAPS_W-1:0]  tap_count;
    logic               discard_load;
    logic [TAPS_W-1:0]  discard_value;
  } prr_cfg_t;

  function automatic logic [RATIO_W-1:0] clamp_ratio(input logic [RATIO_W-1:0] r);
    logic [RATIO_W-1:0] res;
    res = r;
    if (r == '0) res = RATIO_W'(1);
    else if (r > RATIO_MAX) res = RATIO_MAX;
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/prr_front.sv
`default_nettype none

module prr_front
  import prr_pkg::*;
#(
  parameter int COEF_DEPTH = COEF_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [CIDX_W-1:0]          coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  input  logic                       q_ready_i,
  output logic                       q_push_o,
  output prr_item_t                  q_item_o,
  output prr_cfg_t                   cfg_o
);

  logic [RATIO_W-1:0] up_q, up_d;
  logic [RATIO_W-1:0] down_q, down_d;
  logic [TAPS_W-1:0]  taps_q, taps_d;
  logic [TAPS_W-1:0]  disc_q, disc_d;
  logic               wr_c;
  logic [1:0]         idx_c;

  assign pready = 1'b1;
  assign idx_c  = paddr[3:2];
  assign wr_c   = psel && penable && pwrite;

  always_comb begin
    up_d   = up_q;
    down_d = down_q;
    taps_d = taps_q;
    disc_d = disc_q;
    if (wr_c) begin
      unique case (idx_c)
        REG_UP_RATIO:        up_d   = pwdata[RATIO_W-1:0];
        REG_DOWN_RATIO:      down_d = pwdata[RATIO_W-1:0];
        REG_TAP_COUNT:       taps_d = pwdata[TAPS_W-1:0];
        REG_STARTUP_DISCARD: disc_d = pwdata[TAPS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx_c)
      REG_UP_RATIO:        prdata = 32'(up_q);
      REG_DOWN_RATIO:      prdata = 32'(down_q);
      REG_TAP_COUNT:       prdata = 32'(taps_q);
      REG_STARTUP_DISCARD: prdata = 32'(disc_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= UP_RATIO_RST;
      down_q <= DOWN_RATIO_RST;
      taps_q <= TAP_COUNT_RST;
      disc_q <= DISCARD_RST;
    end else begin
      up_q   <= up_d;
      down_q <= down_d;
      taps_q <= taps_d;
      disc_q <= disc_d;
    end
  end

  // Classify the item; flag out-of-range coefficient addresses for the datapath to drop
  assign in_ready_o           = q_ready_i;
  assign q_push_o             = in_valid_i && q_ready_i;
  assign q_item_o.is_coef     = (operation_i == OP_COEF);
  assign q_item_o.sample      = sample_i;
  assign q_item_o.coef_addr   = coef_index_i;
  assign q_item_o.coef_ok     = (int'(coef_index_i) < COEF_DEPTH);
  assign q_item_o.coef_value  = coef_value_i;

  assign cfg_o.up            = clamp_ratio(up_q);
  assign cfg_o.down          = clamp_ratio(down_q);
  assign cfg_o.tap_count     = taps_q;
  assign cfg_o.discard_load  = wr_c && (idx_c == REG_STARTUP_DISCARD);
  assign cfg_o.discard_value = pwdata[TAPS_W-1:0];

endmodule

`default_nettype wire

>>> hdl/prr_queue.sv
`default_nettype none

module prr_queue
  import prr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  prr_item_t item_i,
  output logic      ready_o,
  output logic      valid_o,
  input  logic      pop_i,
  output prr_item_t item_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  prr_item_t      slot_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           do_pop;

  assign ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hdl/prr_back.sv
`default_nettype none

module prr_back
  import prr_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int COEF_DEPTH = COEF_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  prr_cfg_t                   cfg_i,
  input  logic                       item_valid_i,
  input  prr_item_t                  item_i,
  output logic                       item_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] value_o,
  output logic                       last_o
);

  localparam int RA  = $clog2(RING_DEPTH);
  localparam int CA  = $clog2(COEF_DEPTH);
  localparam int KW  = $clog2(COEF_DEPTH + 17);
  localparam int LWR = $clog2(RING_DEPTH + 1);
  localparam int LWC = $clog2(COEF_DEPTH + 1);
  localparam int LW  = (LWR > LWC) ? LWR : LWC;
  localparam int AW  = PROD_W + CA + 1;
  localparam int RW  = AW - 16;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PHASE = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_END   = 3'd4;

  localparam logic signed [AW-1:0] HALF   = AW'(32768);
  localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);

  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];

  logic [2:0]          state_q, state_d;
  logic [RA-1:0]       newest_q, newest_d;
  logic [LW-1:0]       fill_q, fill_d;
  logic [RATIO_W-1:0]  cd_q, cd_d;
  logic [TAPS_W-1:0]   disc_q, disc_d;
  logic [3:0]          p_q, p_d;
  logic                v1_q, v1_d;
  logic                ok1_q, ok1_d;
  logic                v2_q, v2_d;
  logic                pend_valid_q, pend_valid_d;
  logic                out_valid_q, out_valid_d;

  logic [KW-1:0]              k_q, k_d;
  logic [RA-1:0]              pos_q, pos_d;
  logic [LW-1:0]              j_q, j_d;
  logic signed [SAMPLE_W-1:0] samp_rd_q;
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [AW-1:0]       acc_q, acc_d;
  logic signed [SAMPLE_W-1:0] pend_q, pend_d;
  logic signed [SAMPLE_W-1:0] out_value_q, out_value_d;
  logic                       out_last_q, out_last_d;

  logic [KW-1:0]              taps_c;
  logic                       issue_c;
  logic                       ring_we_c, coef_we_c;
  logic [RA-1:0]              newest_dec_c;
  logic [RATIO_W-1:0]         cd_dec_c;
  logic                       last_phase_c;
  logic                       out_free_c;
  logic signed [AW-1:0]       sum_c;
  logic signed [RW-1:0]       rnd_c;
  logic signed [SAMPLE_W-1:0] sat_c;

  assign taps_c = (int'(cfg_i.tap_count) >= COEF_DEPTH) ? KW'(COEF_DEPTH)
                                                         : KW'(cfg_i.tap_count);
  assign issue_c      = (state_q == ST_MAC) && (k_q < taps_c);
  assign newest_dec_c = (newest_q == '0) ? RA'(RING_DEPTH - 1) : newest_q - 1'b1;
  assign cd_dec_c     = (cd_q != '0) ? cd_q - 1'b1 : '0;
  assign last_phase_c = ({1'b0, p_q} == cfg_i.up - 1'b1);
  assign out_free_c   = !out_valid_q || out_ready_i;

  // Signed product at full width
  assign prod_c = samp_rd_q * coef_rd_q;

  // Round half up at bit 16, then saturate
  assign sum_c = acc_q + HALF;
  assign rnd_c = sum_c[AW-1:16];
  always_comb begin
    if (rnd_c > SAT_HI)      sat_c = SAT_HI[SAMPLE_W-1:0];
    else if (rnd_c < SAT_LO) sat_c = SAT_LO[SAMPLE_W-1:0];
    else                     sat_c = rnd_c[SAMPLE_W-1:0];
  end

  always_comb begin
    state_d      = state_q;
    newest_d     = newest_q;
    fill_d       = fill_q;
    cd_d         = cd_q;
    disc_d       = disc_q;
    p_d          = p_q;
    k_d          = k_q;
    pos_d        = pos_q;
    j_d          = j_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    item_pop_o   = 1'b0;
    ring_we_c    = 1'b0;
    coef_we_c    = 1'b0;

    v1_d  = issue_c;
    ok1_d = (j_q < fill_q);
    v2_d  = v1_q;
    acc_d = v2_q ? acc_q + AW'(prod_q) : acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.is_coef) begin
            coef_we_c = item_i.coef_ok;
          end else begin
            ring_we_c = 1'b1;
            newest_d  = newest_dec_c;
            if (fill_q != LW'(RING_DEPTH)) fill_d = fill_q + 1'b1;
            p_d     = '0;
            state_d = ST_PHASE;
          end
        end
      end
      ST_PHASE: begin
        if (cd_dec_c == '0) begin
          cd_d    = cfg_i.down;
          k_d     = KW'(p_q);
          pos_d   = newest_q;
          j_d     = '0;
          acc_d   = '0;
          state_d = ST_MAC;
        end else begin
          cd_d = cd_dec_c;
          if (last_phase_c) state_d = ST_END;
          else p_d = p_q + 1'b1;
        end
      end
      ST_MAC: begin
        if (issue_c) begin
          k_d   = k_q + KW'(cfg_i.up);
          pos_d = (pos_q == RA'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
          j_d   = j_q + 1'b1;
        end else if (!v1_q && !v2_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (disc_q != '0 || !pend_valid_q || out_free_c) begin
          if (disc_q != '0) begin
            disc_d = disc_q - 1'b1;
          end else begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_value_d = pend_q;
              out_last_d  = 1'b0;
            end
            pend_d       = sat_c;
            pend_valid_d = 1'b1;
          end
          if (last_phase_c) state_d = ST_END;
          else begin
            p_d     = p_q + 1'b1;
            state_d = ST_PHASE;
          end
        end
      end
      ST_END: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free_c) begin
          out_valid_d  = 1'b1;
          out_value_d  = pend_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_i.discard_load) disc_d = cfg_i.discard_value;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we_c) ring_mem[newest_dec_c] <= item_i.sample;
    if (issue_c) samp_rd_q <= ring_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we_c) coef_mem[CA'(item_i.coef_addr)] <= item_i.coef_value;
    if (issue_c) coef_rd_q <= coef_mem[k_q[CA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= ok1_q ? prod_c : '0;
    acc_q       <= acc_d;
    k_q         <= k_d;
    pos_q       <= pos_d;
    j_q         <= j_d;
    pend_q      <= pend_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      newest_q     <= '0;
      fill_q       <= '0;
      cd_q         <= RATIO_W'(1);
      disc_q       <= DISCARD_RST;
      p_q          <= '0;
      v1_q         <= 1'b0;
      ok1_q        <= 1'b0;
      v2_q         <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      newest_q     <= newest_d;
      fill_q       <= fill_d;
      cd_q         <= cd_d;
      disc_q       <= disc_d;
      p_q          <= p_d;
      v1_q         <= v1_d;
      ok1_q        <= ok1_d;
      v2_q         <= v2_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

>>> hdl/polyphase_rational_resampler_core.sv
// Timing: a coefficient item is written from the idle state; a sample item's pass through
//   the datapath is set by the single shared multiply-accumulate and lengthened by output stalls.
// Flow: one item at a time in the datapath while a two-entry queue takes more.
// Reset: rst_ni asynchronous, active low; registers to defaults, history reads zero (fill count).
`default_nettype none

module polyphase_rational_resampler_core
  import prr_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int COEF_DEPTH = COEF_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [CIDX_W-1:0]          coef_index_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] value_o,
  output logic                       last_o
);

  // Front: register file plus intake. Each accepted item is tagged as a
  // sample or a coefficient write and pushed into the queue; coefficient
  // addresses beyond the store are flagged so the datapath drops them.
  prr_item_t push_item;
  prr_item_t pop_item;
  prr_cfg_t  cfg;
  logic      q_ready;
  logic      q_push;
  logic      q_valid;
  logic      q_pop;

  prr_front #(
    .COEF_DEPTH(COEF_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .sample_i    (sample_i),
    .coef_index_i(coef_index_i),
    .coef_value_i(coef_value_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_item_o    (push_item),
    .cfg_o       (cfg)
  );

  // Queue: decouples intake from the datapath so the input side keeps
  // taking items while a long filter pass is running.
  prr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .item_o (pop_item)
  );

  // Back: owns the sample ring and coefficient store. For a sample it
  // steps the phases, and for each phase whose countdown expires it runs
  // the multiply-accumulate over taps phase, phase+up, ... through a
  // read / multiply / accumulate pipeline. Each finished output is held
  // back by one so the last one of the item can carry the last flag;
  // the startup discard count drops outputs before they are held.
  prr_back #(
    .RING_DEPTH(RING_DEPTH),
    .COEF_DEPTH(COEF_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_valid_i(q_valid),
    .item_i      (pop_item),
    .item_pop_o  (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

>>> hdl/prr_checker.sv
`default_nettype none

module prr_checker
  import prr_pkg::*;
(
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [3:0]                 paddr,
  input wire logic [31:0]                pwdata,
  input wire logic [31:0]                prdata,
  input wire logic                       pready,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       operation_i,
  input wire logic signed [SAMPLE_W-1:0] sample_i,
  input wire logic [CIDX_W-1:0]          coef_index_i,
  input wire logic signed [COEF_W-1:0]   coef_value_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic signed [SAMPLE_W-1:0] value_o,
  input wire logic                       last_o
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Up ratio and tap count registers read back what was last written
  a_up_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[3:2] == REG_UP_RATIO) |=>
      ((psel && !pwrite && paddr[3:2] == REG_UP_RATIO) |->
        prdata == {27'd0, $past(pwdata[RATIO_W-1:0])}))
    else $error("up_ratio readback mismatch");

  a_taps_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && paddr[3:2] == REG_TAP_COUNT) |=>
      ((psel && !pwrite && paddr[3:2] == REG_TAP_COUNT) |->
        prdata == {22'd0, $past(pwdata[TAPS_W-1:0])}))
    else $error("tap_count readback mismatch");

  // Unused read bits stay zero
  a_prdata_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> prdata[31:TAPS_W] == '0)
    else $error("register read has stray upper bits");

endmodule

bind polyphase_rational_resampler_core prr_checker u_prr_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
  import prr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SIZE   = RING_DEPTH_DEF;
  localparam int COEF_SIZE   = COEF_DEPTH_DEF;
  localparam int COEF_FILL   = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 21;
  localparam int MAX_REPORTS = 20;

  // Kind of one row of the directed stimulus table
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        op;
    logic [15:0] smp;
    logic [8:0]  index;   // coefficient address, or register index for ROW_REG
    logic [31:0] data;    // coefficient value, or register value for ROW_REG
    logic        typed;   // row carries its own single expected output
    logic [15:0] want;
  } stim_row_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } out_sample_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // Configuration port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Item stream in
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i  = OP_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_i     = '0;
  logic [CIDX_W-1:0]          coef_index_i = '0;
  logic signed [COEF_W-1:0]   coef_value_i = '0;

  // Output sample stream
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] value_o;
  logic                       last_o;

  polyphase_rational_resampler_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .sample_i     (sample_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .last_o       (last_o)
  );

  // Shadow of the resampler: its registers and its state, kept in step with every
  // accepted item and every register write.
  logic [RATIO_W-1:0]         up_cfg      = UP_RATIO_RST;
  logic [RATIO_W-1:0]         down_cfg    = DOWN_RATIO_RST;
  logic [TAPS_W-1:0]          taps_cfg    = TAP_COUNT_RST;
  logic [RATIO_W-1:0]         countdown   = 5'd1;
  logic [TAPS_W-1:0]          discard_left = '0;
  logic [8:0]                 newest_pos  = '0;
  logic signed [SAMPLE_W-1:0] ring_mem [RING_SIZE];
  logic signed [COEF_W-1:0]   coef_mem [COEF_SIZE];

  // Output samples still owed by the block, oldest first
  out_sample_t expected_outputs [$];
  out_sample_t head;

  int tx_idle_pct = 36;
  int rx_idle_pct = 59;
  int errors      = 0;
  int n_items     = 0;
  int n_samples   = 0;
  int n_coefs     = 0;
  int n_results   = 0;
  int n_reg_writes = 0;
  int cycle_count = 0;
  bit stream_quiet = 1'b1;

  stim_row_t rows [$];

  function automatic int eff_ratio(input logic [RATIO_W-1:0] r);
    if (r == 0) return 1;
    if (r > 16) return 16;
    return int'(r);
  endfunction

  function automatic int eff_taps();
    return (taps_cfg > COEF_SIZE) ? COEF_SIZE : int'(taps_cfg);
  endfunction

  // One polyphase branch: walk the ring from the newest sample, stepping the
  // coefficient index by the phase count, then round half up and saturate.
  function automatic logic signed [SAMPLE_W-1:0] phase_sum(input int phase, input int stride);
    longint acc;
    int     pos;
    int     k;
    int     n_taps;
    acc    = 0;
    pos    = int'(newest_pos);
    n_taps = eff_taps();
    for (k = phase; k < n_taps; k += stride) begin
      acc += longint'(ring_mem[pos]) * longint'(coef_mem[k]);
      pos = (pos + 1) % RING_SIZE;
    end
    acc = (acc + 64'sd32768) >>> 16;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[SAMPLE_W-1:0];
  endfunction

  // Advance the shadow by one item and queue the output samples it causes.
  function automatic void run_polyphase_step(input logic op, input logic [15:0] smp,
                                             input logic [8:0] idx, input logic [17:0] cval);
    logic signed [SAMPLE_W-1:0] vals [16];
    int n;
    int ups;
    int downs;
    int p;
    n = 0;
    if (op == OP_COEF) begin
      coef_mem[idx] = cval;
      return;
    end
    newest_pos = newest_pos - 9'd1;
    ring_mem[newest_pos] = smp;
    ups   = eff_ratio(up_cfg);
    downs = eff_ratio(down_cfg);
    for (p = 0; p < ups; p++) begin
      countdown = (countdown > 0) ? countdown - 5'd1 : 5'd0;
      if (countdown == 0) begin
        vals[n] = phase_sum(p, ups);
        countdown = 5'(downs);
        // drop start-up outputs, still formed so the countdown stays in step
        if (discard_left > 0) discard_left--;
        else n++;
      end
    end
    for (p = 0; p < n; p++) expected_outputs.push_back('{vals[p], p == n - 1});
  endfunction

  // Cycles for work that yields no output to finish, with room for a full queue
  function automatic int settle_cycles();
    return 3 * (6 * eff_ratio(up_cfg) + eff_taps() + 8);
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] data);
    return '{ROW_REG, OP_SAMPLE, 16'd0, {7'd0, idx}, data, 1'b0, 16'd0};
  endfunction

  function automatic stim_row_t coef_row(input logic [8:0] idx, input logic [17:0] cval);
    return '{ROW_ITEM, OP_COEF, 16'd0, idx, {14'd0, cval}, 1'b0, 16'd0};
  endfunction

  function automatic stim_row_t sample_row(input logic [15:0] smp, input logic typed,
                                           input logic [15:0] want);
    return '{ROW_ITEM, OP_SAMPLE, smp, 9'd0, 32'd0, typed, want};
  endfunction

  function automatic logic [31:0] pick_ratio();
    case ($urandom_range(9))
      0:       return 32'($urandom_range(17, 31));
      1:       return 32'd0;
      default: return 32'($urandom_range(1, 16));
    endcase
  endfunction

  // Tap counts stay within the filled part of the coefficient store
  function automatic logic [31:0] pick_taps();
    case ($urandom_range(9))
      0:       return 32'($urandom_range(65, COEF_FILL));
      1:       return 32'(COEF_FILL);
      default: return 32'($urandom_range(1, 64));
    endcase
  endfunction

  // Present one item and hold it until the block takes it, then advance the shadow.
  // A typed row replaces the shadow's outputs with its own single expectation.
  task automatic send_item(input logic op, input logic [15:0] smp, input logic [8:0] idx,
                           input logic [17:0] cval, input logic typed,
                           input logic [15:0] want);
    int n0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    sample_i     <= smp;
    coef_index_i <= idx;
    coef_value_i <= cval;
    do @(posedge clk_i); while (!in_ready_o);
    n0 = expected_outputs.size();
    run_polyphase_step(op, smp, idx, cval);
    if (typed) begin
      while (expected_outputs.size() > n0) void'(expected_outputs.pop_back());
      expected_outputs.push_back('{want, 1'b1});
    end
    n_items++;
    if (op == OP_COEF) n_coefs++;
    else n_samples++;
    stream_quiet = 1'b0;
  endtask

  // Drop valid, wait for every owed output, then let silent work drain.
  task automatic hold_off();
    int n_wait;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_outputs.size() != 0);
    n_wait = settle_cycles();
    repeat (n_wait) @(posedge clk_i);
    stream_quiet = 1'b1;
  endtask

  // Setup cycle, access cycle; the register takes pwdata at the end of access.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_UP_RATIO:   up_cfg   = data[RATIO_W-1:0];
      REG_DOWN_RATIO: down_cfg = data[RATIO_W-1:0];
      REG_TAP_COUNT:  taps_cfg = data[TAPS_W-1:0];
      REG_STARTUP_DISCARD: discard_left = data[TAPS_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // Receiver: stall at random at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each output sample taken by the receiver against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_outputs.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: output with nothing owed, value %0d last %0b", $time, value_o, last_o);
        errors++;
      end else begin
        head = expected_outputs.pop_front();
        if (value_o !== head.value) begin
          if (errors < MAX_REPORTS)
            $display("%0t: value mismatch, expected %0d got %0d", $time, head.value, value_o);
          errors++;
        end
        if (last_o !== head.last) begin
          if (errors < MAX_REPORTS)
            $display("%0t: last mismatch, expected %0b got %0b", $time, head.last, last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d outputs still owed", $time, expected_outputs.size());
      $display("FAIL polyphase_rational_resampler_core");
      $finish;
    end
  end

  initial begin
    foreach (ring_mem[i]) ring_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the low part of the coefficient store first; no tap count below ever
    // reaches past it. Keep the taps small so long filters rarely saturate.
    for (int i = 0; i < COEF_FILL; i++)
      send_item(OP_COEF, 16'd0, 9'(i), 18'($urandom_range(0, 2047) - 1024), 1'b0, 16'd0);

    // Directed part. The first sample runs on the reset ratios with the tap count
    // cut to the filled store; two silent samples then bring the countdown back
    // to one before the typed rows.
    rows.push_back(reg_row(REG_TAP_COUNT, 32'(COEF_FILL)));
    rows.push_back(sample_row(16'd20000, 1'b0, 16'd0));
    rows.push_back(reg_row(REG_TAP_COUNT, 32'd1));
    rows.push_back(reg_row(REG_UP_RATIO, 32'd1));
    rows.push_back(reg_row(REG_DOWN_RATIO, 32'd1));
    rows.push_back(reg_row(REG_STARTUP_DISCARD, 32'd0));
    rows.push_back(coef_row(9'd0, 18'h10000));           // unity gain
    rows.push_back(sample_row(16'h1234, 1'b0, 16'd0));
    rows.push_back(sample_row(16'hBEEF, 1'b0, 16'd0));
    rows.push_back(sample_row(16'h0000, 1'b1, 16'h0000));
    rows.push_back(sample_row(16'h7FFF, 1'b1, 16'h7FFF));
    rows.push_back(sample_row(16'h8000, 1'b1, 16'h8000));
    rows.push_back(sample_row(16'h0001, 1'b1, 16'h0001));
    rows.push_back(coef_row(9'd0, 18'h1FFFF));           // largest positive tap
    rows.push_back(sample_row(16'h8000, 1'b1, 16'h8000));
    rows.push_back(sample_row(16'h7FFF, 1'b1, 16'h7FFF));
    rows.push_back(coef_row(9'd0, 18'h20000));           // most negative tap
    rows.push_back(sample_row(16'h8000, 1'b1, 16'h7FFF));
    rows.push_back(sample_row(16'h7FFF, 1'b1, 16'h8000));
    rows.push_back(coef_row(9'd0, 18'h08000));           // one half: exercise round half up
    rows.push_back(sample_row(16'h0001, 1'b1, 16'h0001));
    rows.push_back(sample_row(16'hFFFF, 1'b1, 16'h0000));
    rows.push_back(coef_row(9'd511, 18'h3FFFF));         // top address, all ones
    rows.push_back(reg_row(REG_TAP_COUNT, 32'd0));       // no taps: silent zero output
    rows.push_back(sample_row(16'h1234, 1'b1, 16'h0000));
    rows.push_back(reg_row(REG_UP_RATIO, 32'd0));        // zero ratio acts as one
    rows.push_back(sample_row(16'h7FFF, 1'b1, 16'h0000));
    rows.push_back(reg_row(REG_TAP_COUNT, 32'(COEF_FILL))); // longest filled filter
    rows.push_back(reg_row(REG_UP_RATIO, 32'd31));       // oversize ratio clamps to 16
    rows.push_back(reg_row(REG_DOWN_RATIO, 32'd16));
    rows.push_back(sample_row(16'h4000, 1'b0, 16'd0));
    rows.push_back(reg_row(REG_DOWN_RATIO, 32'd0));      // sixteen outputs per sample
    rows.push_back(sample_row(16'hC000, 1'b0, 16'd0));
    rows.push_back(reg_row(REG_STARTUP_DISCARD, 32'd20)); // drop all of one, part of next
    rows.push_back(sample_row(16'h2000, 1'b0, 16'd0));
    rows.push_back(sample_row(16'hE000, 1'b0, 16'd0));

    foreach (rows[r]) begin
      if (rows[r].kind == ROW_REG) begin
        if (!stream_quiet) hold_off();
        write_reg(rows[r].index[1:0], rows[r].data);
      end else begin
        send_item(rows[r].op, rows[r].smp, rows[r].index, rows[r].data[17:0],
                  rows[r].typed, rows[r].want);
      end
    end

    // Random part: one register setting per phase, idling swapped in the second third and off in the last
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES / 3) begin
        tx_idle_pct = 59;
        rx_idle_pct = 36;
      end else if (ph == 2 * PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      hold_off();
      if (ph == 0) begin
        // widest ratio with the longest start-up drop
        write_reg(REG_UP_RATIO, 32'd16);
        write_reg(REG_DOWN_RATIO, 32'd1);
        write_reg(REG_TAP_COUNT, 32'd32);
        write_reg(REG_STARTUP_DISCARD, 32'd512);
      end else if (ph == 1) begin
        // longest filled filter, sparse outputs
        write_reg(REG_UP_RATIO, 32'd1);
        write_reg(REG_DOWN_RATIO, 32'd16);
        write_reg(REG_TAP_COUNT, 32'(COEF_FILL));
        write_reg(REG_STARTUP_DISCARD, 32'd0);
      end else begin
        write_reg(REG_UP_RATIO, pick_ratio());
        write_reg(REG_DOWN_RATIO, pick_ratio());
        write_reg(REG_TAP_COUNT, pick_taps());
        write_reg(REG_STARTUP_DISCARD, 32'($urandom_range(0, 12)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender once mid-phase until the block has caught up
        if (ph == 5 && n == PHASE_ITEMS / 2) hold_off();
        if ($urandom_range(99) < 15) begin
          send_item(OP_COEF, 16'd0, 9'($urandom_range(0, COEF_SIZE - 1)),
                    ($urandom_range(3) == 0) ? 18'($urandom)
                                             : 18'($urandom_range(0, 4095) - 2048),
                    1'b0, 16'd0);
        end else begin
          case ($urandom_range(9))
            0:       send_item(OP_SAMPLE, 16'h7FFF, 9'd0, 18'd0, 1'b0, 16'd0);
            1:       send_item(OP_SAMPLE, 16'h8000, 9'd0, 18'd0, 1'b0, 16'd0);
            default: send_item(OP_SAMPLE, 16'($urandom), 9'd0, 18'd0, 1'b0, 16'd0);
          endcase
        end
      end
    end

    hold_off();
    $display("Sent %0d items (%0d samples, %0d coefficient writes) across %0d register writes.",
             n_items, n_samples, n_coefs, n_reg_writes);
    $display("Checked %0d output samples in %0d cycles, %0d mismatches.",
             n_results, cycle_count, errors);
    if (expected_outputs.size() != 0) begin
      $display("%0t: %0d outputs never arrived", $time, expected_outputs.size());
      errors += expected_outputs.size();
    end
    if (errors == 0) begin
      $display("PASS polyphase_rational_resampler_core");
    end else begin
      $display("FAIL polyphase_rational_resampler_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/prr_pkg.sv
hdl/prr_front.sv
hdl/prr_queue.sv
hdl/prr_back.sv
hdl/polyphase_rational_resampler_core.sv
hdl/prr_checker.sv
tb/testbench.sv
